>>> rtl/core/assert_macros.svh
// Assertion helpers used by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Consequence checked in the cycle after the condition.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/core/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

    localparam logic [7:0] STAR_CHAR = 8'd42;
    localparam logic [7:0] DOT_CHAR  = 8'd46;

    typedef logic [1:0] pix_class_t;

    localparam pix_class_t CLS_OTHER = 2'd0;
    localparam pix_class_t CLS_DOT   = 2'd1;
    localparam pix_class_t CLS_STAR  = 2'd2;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int ROW_W          = 12;
    localparam int COUNT_W        = 23;
    localparam int MAX_HEIGHT     = 4096;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [0:0] reg_index_t;

    localparam reg_index_t REG_FRAME_WIDTH  = 1'd0;
    localparam reg_index_t REG_FRAME_HEIGHT = 1'd1;

    // 3x3 window of classes; cell (row, col) sits at bits 2*(3*row+col).
    typedef logic [17:0] window_t;

    // Per-pixel decision inputs. rv/cv mark which of the frame rows r-2..r+1 and
    // columns c-2..c+1 lie inside the frame.
    typedef struct packed {
        logic       last_col;
        logic       last_row;
        logic [3:0] rv;
        logic [3:0] cv;
    } pix_flags_t;

    localparam int ROW_STEP [8] = '{-1, -1, 0, 1, 1,  1,  0, -1};
    localparam int COL_STEP [8] = '{ 0,  1, 1, 1, 0, -1, -1, -1};

    function automatic pix_class_t classify(logic [7:0] ch);
        pix_class_t cls;
        if (ch == DOT_CHAR)
            cls = CLS_DOT;
        else if (ch == STAR_CHAR)
            cls = CLS_STAR;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

    function automatic pix_class_t cell_of(window_t win, int row, int col);
        return win[2*(3*row+col) +: 2];
    endfunction

    // Centre at window cell (r0, c0). Grid row/col 3 lies beyond the window, so an
    // in-frame neighbour there means the centre cannot be decided as isolated.
    function automatic logic decide_centre(window_t win, logic [3:0] rv, logic [3:0] cv,
                                           int r0, int c0);
        logic ok;
        int   rr;
        int   cc;
        ok = rv[r0] && cv[c0] && (cell_of(win, r0, c0) == CLS_STAR);
        for (int k = 0; k < 8; k++)
        begin
            rr = r0 + ROW_STEP[k];
            cc = c0 + COL_STEP[k];
            if (rv[rr] && cv[cc])
            begin
                if (rr > 2 || cc > 2)
                    ok = 1'b0;
                else if (cell_of(win, rr, cc) != CLS_DOT)
                    ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/isolated_pixel_counter.sv
// Counts isolated star pixels ('*' whose in-frame 8-neighbours are all '.') in a
// raster frame of characters, one pixel per beat. Frame width and height come from
// the configuration port and may be written whenever no pixel is in flight. One
// pixel is accepted every clock unless the sweep or a stalled count blocks it; a
// frame's count is registered for the master side as its last pixel leaves the
// processing register, and the next frame may stream in meanwhile. After reset the
// line store is swept to zero, one column per cycle, so s_tready stays low until
// all MAX_WIDTH columns are clear. The store's read is registered; a stalled count
// blocks input only when the next frame's last pixel is ready to be processed.
`default_nettype none

module isolated_pixel_counter
    import ipc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pixel_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [22:0] star_count, [23] zero
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > FRAME_WIDTH_W) ?
                        $clog2(MAX_WIDTH + 1) : FRAME_WIDTH_W;
    localparam int CX = WW + 2;
    localparam int RX = FRAME_HEIGHT_W + 1;

    // Configuration.
    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_W'(1024);
            frame_height_reg <= FRAME_HEIGHT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [WW-1:0]             w_eff;
    logic [FRAME_HEIGHT_W-1:0] h_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (WW'(frame_width_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = FRAME_HEIGHT_W'(1);
        else if (frame_height_reg > FRAME_HEIGHT_W'(MAX_HEIGHT))
            h_eff = FRAME_HEIGHT_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    // Control state.
    logic                clr_active_reg;
    logic [CW-1:0]       clr_idx_reg;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic                s1_valid_reg;
    logic [CW-1:0]       s1_idx_reg;
    pix_class_t          s1_code_reg;
    pix_flags_t          s1_flags_reg;
    pix_flags_t          flags_next;
    logic [3:0]          rd_reg;
    logic                fwd_reg;
    logic [3:0]          fwd_data_reg;
    window_t             window_reg;
    window_t             window_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic accept;
    logic s1_emit;
    logic s1_advance;

    // Each entry holds {class two rows up, class one row up}.
    logic [3:0] line_mem [MAX_WIDTH];

    assign s1_emit    = s1_flags_reg.last_col && s1_flags_reg.last_row;
    assign s1_advance = s1_valid_reg && (!s1_emit || !out_valid_reg || m_tready);
    assign s_tready   = !clr_active_reg && (!s1_valid_reg || s1_advance);
    assign accept     = s_tvalid && s_tready;

    // Position decode for the incoming pixel.
    logic [CX-1:0] c_x;
    logic [CX-1:0] w_x;
    logic [RX-1:0] r_x;
    logic [RX-1:0] h_x;

    always_comb
    begin
        c_x = CX'(col_reg);
        w_x = CX'(w_eff);
        r_x = RX'(row_reg);
        h_x = RX'(h_eff);

        flags_next.last_col = c_x >= (w_x - CX'(1));
        flags_next.last_row = r_x >= (h_x - RX'(1));
        flags_next.rv[0] = (r_x >= RX'(2)) && (r_x < h_x + RX'(2));
        flags_next.rv[1] = (r_x >= RX'(1)) && (r_x < h_x + RX'(1));
        flags_next.rv[2] = r_x < h_x;
        flags_next.rv[3] = (r_x + RX'(1)) < h_x;
        flags_next.cv[0] = (c_x >= CX'(2)) && (c_x < w_x + CX'(2));
        flags_next.cv[1] = (c_x >= CX'(1)) && (c_x < w_x + CX'(1));
        flags_next.cv[2] = c_x < w_x;
        flags_next.cv[3] = (c_x + CX'(1)) < w_x;

        if (flags_next.last_col && flags_next.last_row)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (flags_next.last_col)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    // Line store values for the pixel in the processing register. A write landing
    // on the address read in the same cycle is bypassed.
    pix_class_t up_eff;
    pix_class_t mid_eff;

    assign up_eff  = fwd_reg ? fwd_data_reg[3:2] : rd_reg[3:2];
    assign mid_eff = fwd_reg ? fwd_data_reg[1:0] : rd_reg[1:0];

    logic [2:0]       add;
    logic [COUNT_W:0] sum;

    always_comb
    begin
        window_next = window_reg;
        for (int wr = 0; wr < 3; wr++)
        begin
            window_next[6*wr +: 2]     = window_reg[6*wr + 2 +: 2];
            window_next[6*wr + 2 +: 2] = window_reg[6*wr + 4 +: 2];
        end
        window_next[4 +: 2]  = up_eff;
        window_next[10 +: 2] = mid_eff;
        window_next[16 +: 2] = s1_code_reg;

        add = 3'(decide_centre(window_next, s1_flags_reg.rv, s1_flags_reg.cv, 1, 1))
            + 3'(s1_flags_reg.last_col &&
                 decide_centre(window_next, s1_flags_reg.rv, s1_flags_reg.cv, 1, 2))
            + 3'(s1_flags_reg.last_row &&
                 decide_centre(window_next, s1_flags_reg.rv, s1_flags_reg.cv, 2, 1))
            + 3'(s1_emit &&
                 decide_centre(window_next, s1_flags_reg.rv, s1_flags_reg.cv, 2, 2));

        sum = {1'b0, count_reg} + (COUNT_W+1)'(add);
        if (sum > (COUNT_W+1)'(COUNT_MAX))
            count_next = COUNT_MAX;
        else
            count_next = sum[COUNT_W-1:0];
    end

    // Line store: sweep after reset, then one read on accept and one write as the
    // pixel leaves the processing register.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            line_mem[clr_idx_reg] <= '0;
        else if (s1_advance)
            line_mem[s1_idx_reg] <= {mid_eff, s1_code_reg};

        if (accept)
        begin
            rd_reg       <= line_mem[col_reg];
            fwd_data_reg <= {mid_eff, s1_code_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_idx_reg == CW'(MAX_WIDTH - 1))
                clr_active_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_idx_reg   <= '0;
            s1_code_reg  <= CLS_OTHER;
            s1_flags_reg <= '0;
            fwd_reg      <= 1'b0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= 1'b1;
            s1_idx_reg   <= col_reg;
            s1_code_reg  <= classify(s_tdata);
            s1_flags_reg <= flags_next;
            fwd_reg      <= s1_advance && (s1_idx_reg == col_reg);
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
        end
        else if (s1_advance)
        begin
            window_reg <= window_next;
            count_reg  <= s1_emit ? '0 : count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emit)
            out_count_reg <= count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg};

    `ASSERT_IMPLIES(a_no_accept_in_clear, clr_active_reg, !s_tready,
                    "pixel accepted during line store sweep")
    `ASSERT_IMPLIES(a_stall_blocks_input, s1_valid_reg && !s1_advance, !accept,
                    "pixel accepted while processing register is stalled")
    `ASSERT_NEXT(a_count_cleared, s1_advance && s1_emit, count_reg == '0,
                 "running count not cleared after frame end")
    `ASSERT_ALWAYS(a_col_in_range, col_reg <= CW'(MAX_WIDTH - 1),
                   "column position beyond line store depth")
    `ASSERT_IMPLIES(a_result_from_frame_end, $rose(out_valid_reg),
                    $past(s1_advance && s1_emit),
                    "count presented without a frame end")

endmodule

`default_nettype wire
